### hdl/etx_pkg.sv
// shared types, character codes and defaults for the expression tokenizer
package etx_pkg;

    // default sizing of the token stores
    localparam int NAME_CHARS_DEF = 8;
    localparam int INT_BITS_DEF   = 32;
    localparam int FRAC_MAX_DEF   = 9;

    // fixed widths of the result fields
    localparam int NAME_TEXT_W = 64;
    localparam int NAME_LEN_W  = 4;
    localparam int INT_PART_W  = 32;
    localparam int FRAC_W      = 30;
    localparam int FRAC_CNT_W  = 4;

    // result queue depth, room for two tokens per character plus two in flight
    localparam int Q_DEPTH = 4;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [3:0] {
        M_IDLE = 4'd0,
        M_NAME = 4'd1,
        M_INT  = 4'd2,
        M_FRAC = 4'd3,
        M_AMP  = 4'd4,
        M_BAR  = 4'd5,
        M_EQ   = 4'd6,
        M_LT   = 4'd7,
        M_GT   = 4'd8,
        M_BANG = 4'd9
    } t_lex_mode;

    typedef enum logic [4:0] {
        KIND_NAME   = 5'd0,
        KIND_NUMBER = 5'd1,
        KIND_END    = 5'd2,
        KIND_PLUS   = 5'd3,
        KIND_MINUS  = 5'd4,
        KIND_MUL    = 5'd5,
        KIND_DIV    = 5'd6,
        KIND_LPAR   = 5'd7,
        KIND_RPAR   = 5'd8,
        KIND_AND    = 5'd9,
        KIND_OR     = 5'd10,
        KIND_EQ     = 5'd11,
        KIND_LT     = 5'd12,
        KIND_LTEQ   = 5'd13,
        KIND_GT     = 5'd14,
        KIND_GTEQ   = 5'd15,
        KIND_NE     = 5'd16,
        KIND_NOT    = 5'd17,
        KIND_ERROR  = 5'd18
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_AMP    = 3'd1,
        ERR_BAR    = 3'd2,
        ERR_EQ     = 3'd3,
        ERR_CHAR   = 3'd4
    } t_err;

    typedef struct packed {
        t_kind                   kind;
        logic [NAME_TEXT_W-1:0]  name_text;
        logic [NAME_LEN_W-1:0]   name_length;
        logic                    name_truncated;
        logic [INT_PART_W-1:0]   int_part;
        logic                    int_saturated;
        logic [FRAC_W-1:0]       frac_digits;
        logic [FRAC_CNT_W-1:0]   frac_count;
        t_err                    error_code;
        logic [7:0]              error_char;
        logic                    last;
    } t_token;

    // token with only its kind set
    function automatic t_token blank_token(input t_kind kind);
        t_token t;
        t      = '0;
        t.kind = kind;
        return t;
    endfunction

endpackage

### hdl/etx_lexer.sv
// lexer state and per-character token decode
module etx_lexer #(
    parameter int NAME_CHARS = etx_pkg::NAME_CHARS_DEF,
    parameter int INT_BITS   = etx_pkg::INT_BITS_DEF,
    parameter int FRAC_MAX   = etx_pkg::FRAC_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_char,
    output logic [1:0]        o_res_valid,
    output etx_pkg::t_token   o_res [2]
);
    import etx_pkg::*;

    localparam int NAME_BITS = 8 * NAME_CHARS;
    localparam int NAME_CW   = $clog2(NAME_CHARS + 1);
    localparam int INT_EXT   = INT_BITS + 4;
    localparam int FRAC_SW   = $clog2(FRAC_MAX + 1);
    localparam int FRAC_EXT  = FRAC_W + 4;

    t_lex_mode              r_mode, n_mode;
    logic [NAME_BITS-1:0]   r_name_store, n_name_store;
    logic [NAME_CW-1:0]     r_name_count, n_name_count;
    logic                   r_name_ovf, n_name_ovf;
    logic [INT_BITS-1:0]    r_int_acc, n_int_acc;
    logic                   r_int_ovf, n_int_ovf;
    logic [FRAC_W-1:0]      r_frac_acc, n_frac_acc;
    logic [FRAC_SW-1:0]     r_frac_seen, n_frac_seen;

    // character classes
    logic       is_letter, is_digit, is_space, is_name_ch;
    logic [3:0] digit;

    assign is_letter  = (i_char >= 8'h61 && i_char <= 8'h7A) ||
                        (i_char >= 8'h41 && i_char <= 8'h5A);
    assign is_digit   = (i_char >= 8'h30 && i_char <= 8'h39);
    assign is_space   = (i_char == CH_SPACE) || (i_char >= CH_TAB && i_char <= CH_CR);
    assign is_name_ch = is_letter || is_digit || (i_char == CH_UNDER);
    assign digit      = i_char[3:0];

    // character continues the pending token
    logic consumed;
    always_comb begin
        unique case (r_mode) inside
            M_NAME:             consumed = is_name_ch;
            M_INT:              consumed = is_digit || (i_char == CH_DOT);
            M_FRAC:             consumed = is_digit;
            M_AMP:              consumed = (i_char == CH_AMP);
            M_BAR:              consumed = (i_char == CH_BAR);
            M_EQ:               consumed = (i_char == CH_EQ);
            M_LT, M_GT, M_BANG: consumed = (i_char == CH_EQ);
            default:            consumed = 1'b0;
        endcase
    end

    // accumulator updates
    logic [NAME_BITS-1:0] name_added;
    logic                 name_room;
    logic [INT_EXT-1:0]   int_prod;
    logic                 int_sat;
    logic [FRAC_EXT-1:0]  frac_prod;

    assign name_room = r_name_count < NAME_CW'(NAME_CHARS);

    always_comb begin
        name_added = r_name_store;
        for (int k = 0; k < NAME_CHARS; k++) begin
            if (r_name_count == NAME_CW'(k)) begin
                name_added[8*k +: 8] = i_char;
            end
        end
    end

    assign int_prod  = (INT_EXT'(r_int_acc) << 3) + (INT_EXT'(r_int_acc) << 1) +
                       INT_EXT'(digit);
    assign int_sat   = r_int_ovf || (|int_prod[INT_EXT-1:INT_BITS]);
    assign frac_prod = (FRAC_EXT'(r_frac_acc) << 3) + (FRAC_EXT'(r_frac_acc) << 1) +
                       FRAC_EXT'(digit);

    // mode entered from idle on a character
    t_lex_mode idle_mode;
    always_comb begin
        if (is_letter) begin
            idle_mode = M_NAME;
        end else if (is_digit) begin
            idle_mode = M_INT;
        end else begin
            case (i_char)
                CH_AMP:  idle_mode = M_AMP;
                CH_BAR:  idle_mode = M_BAR;
                CH_EQ:   idle_mode = M_EQ;
                CH_LT:   idle_mode = M_LT;
                CH_GT:   idle_mode = M_GT;
                CH_BANG: idle_mode = M_BANG;
                default: idle_mode = M_IDLE;
            endcase
        end
    end

    // next state
    always_comb begin
        n_mode       = r_mode;
        n_name_store = r_name_store;
        n_name_count = r_name_count;
        n_name_ovf   = r_name_ovf;
        n_int_acc    = r_int_acc;
        n_int_ovf    = r_int_ovf;
        n_frac_acc   = r_frac_acc;
        n_frac_seen  = r_frac_seen;
        if (consumed) begin
            unique case (r_mode) inside
                M_NAME: begin
                    if (name_room) begin
                        n_name_store = name_added;
                        n_name_count = r_name_count + NAME_CW'(1);
                    end else begin
                        n_name_ovf = 1'b1;
                    end
                end
                M_INT: begin
                    if (is_digit) begin
                        n_int_acc = int_sat ? {INT_BITS{1'b1}} : int_prod[INT_BITS-1:0];
                        n_int_ovf = int_sat;
                    end else begin
                        n_mode = M_FRAC;
                    end
                end
                M_FRAC: begin
                    if (r_frac_seen < FRAC_SW'(FRAC_MAX)) begin
                        n_frac_acc  = frac_prod[FRAC_W-1:0];
                        n_frac_seen = r_frac_seen + FRAC_SW'(1);
                    end
                end
                default: begin
                    // two-character operator finished
                    n_mode       = M_IDLE;
                    n_name_store = '0;
                    n_name_count = '0;
                    n_name_ovf   = 1'b0;
                    n_int_acc    = '0;
                    n_int_ovf    = 1'b0;
                    n_frac_acc   = '0;
                    n_frac_seen  = '0;
                end
            endcase
        end else begin
            // character handled afresh from idle
            n_mode       = idle_mode;
            n_name_store = is_letter ? NAME_BITS'(i_char) : '0;
            n_name_count = is_letter ? NAME_CW'(1) : '0;
            n_name_ovf   = 1'b0;
            n_int_acc    = is_digit ? INT_BITS'(digit) : '0;
            n_int_ovf    = 1'b0;
            n_frac_acc   = '0;
            n_frac_seen  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_name_store <= '0;
            r_name_count <= '0;
            r_name_ovf   <= 1'b0;
            r_int_acc    <= '0;
            r_int_ovf    <= 1'b0;
            r_frac_acc   <= '0;
            r_frac_seen  <= '0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_name_store <= n_name_store;
            r_name_count <= n_name_count;
            r_name_ovf   <= n_name_ovf;
            r_int_acc    <= n_int_acc;
            r_int_ovf    <= n_int_ovf;
            r_frac_acc   <= n_frac_acc;
            r_frac_seen  <= n_frac_seen;
        end
    end

    // token of the pending mode, flushed or completed by this character
    t_token pend_tok;
    logic   pend_valid;
    always_comb begin
        pend_tok   = blank_token(KIND_ERROR);
        pend_valid = (r_mode != M_IDLE) && !(consumed && (r_mode == M_NAME ||
                     r_mode == M_INT || r_mode == M_FRAC));
        unique case (r_mode) inside
            M_NAME: begin
                pend_tok                = blank_token(KIND_NAME);
                pend_tok.name_text      = NAME_TEXT_W'(r_name_store);
                pend_tok.name_length    = NAME_LEN_W'(r_name_count);
                pend_tok.name_truncated = r_name_ovf;
            end
            M_INT, M_FRAC: begin
                pend_tok               = blank_token(KIND_NUMBER);
                pend_tok.int_part      = INT_PART_W'(r_int_acc);
                pend_tok.int_saturated = r_int_ovf;
                pend_tok.frac_digits   = r_frac_acc;
                pend_tok.frac_count    = FRAC_CNT_W'(r_frac_seen);
            end
            M_AMP: begin
                if (consumed) begin
                    pend_tok = blank_token(KIND_AND);
                end else begin
                    pend_tok.error_code = ERR_AMP;
                    pend_tok.error_char = CH_AMP;
                end
            end
            M_BAR: begin
                if (consumed) begin
                    pend_tok = blank_token(KIND_OR);
                end else begin
                    pend_tok.error_code = ERR_BAR;
                    pend_tok.error_char = CH_BAR;
                end
            end
            M_EQ: begin
                if (consumed) begin
                    pend_tok = blank_token(KIND_EQ);
                end else begin
                    pend_tok.error_code = ERR_EQ;
                    pend_tok.error_char = CH_EQ;
                end
            end
            M_LT:    pend_tok = blank_token(consumed ? KIND_LTEQ : KIND_LT);
            M_GT:    pend_tok = blank_token(consumed ? KIND_GTEQ : KIND_GT);
            M_BANG:  pend_tok = blank_token(consumed ? KIND_NE : KIND_NOT);
            default: pend_tok = blank_token(KIND_ERROR);
        endcase
    end

    // token emitted straight from idle
    t_token idle_tok;
    logic   idle_emits;
    always_comb begin
        idle_tok   = blank_token(KIND_ERROR);
        idle_emits = 1'b1;
        if (is_space || is_letter || is_digit) begin
            idle_emits = 1'b0;
        end else begin
            case (i_char)
                CH_NUL:   idle_tok = blank_token(KIND_END);
                CH_PLUS:  idle_tok = blank_token(KIND_PLUS);
                CH_MINUS: idle_tok = blank_token(KIND_MINUS);
                CH_STAR:  idle_tok = blank_token(KIND_MUL);
                CH_SLASH: idle_tok = blank_token(KIND_DIV);
                CH_LPAR:  idle_tok = blank_token(KIND_LPAR);
                CH_RPAR:  idle_tok = blank_token(KIND_RPAR);
                CH_AMP, CH_BAR, CH_EQ, CH_LT, CH_GT, CH_BANG: idle_emits = 1'b0;
                default: begin
                    idle_tok.error_code = ERR_CHAR;
                    idle_tok.error_char = i_char;
                end
            endcase
        end
    end

    // pack results in order, flushed token first
    logic idle_valid;
    assign idle_valid = !consumed && idle_emits;

    always_comb begin
        if (pend_valid) begin
            o_res[0]    = pend_tok;
            o_res[1]    = idle_tok;
            o_res_valid = {idle_valid, 1'b1};
        end else begin
            o_res[0]    = idle_tok;
            o_res[1]    = idle_tok;
            o_res_valid = {1'b0, idle_valid};
        end
        o_res[0].last = !o_res_valid[1];
        o_res[1].last = 1'b1;
    end

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid[1] |-> o_res_valid[0] && !o_res[0].last && o_res[1].last)
        else $error("second result without a non-last first result");

    a_pair_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid[1] |-> r_mode != M_IDLE)
        else $error("two results from idle");

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_char == CH_NUL) |=> r_mode == M_IDLE)
        else $error("end of text left a token pending");

endmodule

### hdl/etx_result_queue.sv
// small register queue for result tokens, up to two pushes per cycle
module etx_result_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push,
    input  etx_pkg::t_token   i_push_tok [2],
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output etx_pkg::t_token   o_head
);
    import etx_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_token             r_entry [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wr_second;
    logic [CNT_W-1:0]   push_n;
    logic               pop_ok;

    assign wr_second = r_wr + PTR_W'(1);
    assign push_n    = CNT_W'(i_push[0]) + CNT_W'(i_push[1]);
    assign pop_ok    = i_pop && (r_count != '0);

    always_comb begin
        n_wr    = r_wr + PTR_W'(push_n);
        n_rd    = pop_ok ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count + push_n - CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push[0]) begin
            r_entry[r_wr] <= i_push_tok[0];
        end
        if (i_push[1]) begin
            r_entry[wr_second] <= i_push_tok[1];
        end
    end

    assign o_valid = (r_count != '0);
    // keep room for a full pair of results
    assign o_full  = r_count > CNT_W'(Q_DEPTH - 2);
    assign o_head  = r_entry[r_rd];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push != 2'b00) |-> !o_full)
        else $error("push into a full result queue");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && i_push == 2'b00) |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("pop did not drain the queue");

endmodule

### hdl/expression_tokenizer_core.sv
// top level of the expression tokenizer: lexer plus result queue
//
// usage
//   input channel: one ASCII character per transaction on i_char_in, taken
//   when i_valid is high and o_stall is low; a zero character marks end of
//   text. output channel: one token per transaction on the o_* field ports,
//   taken when o_valid is high and i_stall is low; o_last marks the final
//   token caused by one character.
//   a character either extends the pending token or flushes it, so it gives
//   zero, one or two tokens (a flushed token, then one from the character).
//   a token is written into the result queue when the character that
//   completes it is taken. throughput: one character per cycle while
//   o_stall is low; the token rate is bounded by one per cycle at the
//   output, so bursts of two-token characters fill the four-entry result
//   queue. o_stall rises once the queue holds more than two tokens, keeping
//   room for a full pair; while the receiver stalls, the head token holds and
//   characters keep being taken until that point.
//   reset (synchronous, active low) empties the queue and returns the lexer
//   to idle with all accumulators cleared.
module expression_tokenizer_core #(
    parameter int NAME_CHARS = etx_pkg::NAME_CHARS_DEF,
    parameter int INT_BITS   = etx_pkg::INT_BITS_DEF,
    parameter int FRAC_MAX   = etx_pkg::FRAC_MAX_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // character input
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [7:0]   i_char_in,
    // token output
    output logic         o_valid,
    input  logic         i_stall,
    output logic [4:0]   o_token_kind,
    output logic [63:0]  o_name_text,
    output logic [3:0]   o_name_length,
    output logic         o_name_truncated,
    output logic [31:0]  o_int_part,
    output logic         o_int_saturated,
    output logic [29:0]  o_frac_digits,
    output logic [3:0]   o_frac_count,
    output logic [2:0]   o_error_code,
    output logic [7:0]   o_error_char,
    output logic         o_last
);
    import etx_pkg::*;

    logic       in_accept;
    logic       q_full;
    logic [1:0] res_valid;
    t_token     res_tok [2];
    t_token     head;

    // character taken only while the queue has room for two tokens
    assign in_accept = i_valid && !q_full;
    assign o_stall   = q_full;

    etx_lexer #(
        .NAME_CHARS (NAME_CHARS),
        .INT_BITS   (INT_BITS),
        .FRAC_MAX   (FRAC_MAX)
    ) u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_char      (i_char_in),
        .o_res_valid (res_valid),
        .o_res       (res_tok)
    );

    // results only count when their character is actually taken
    etx_result_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid & {2{in_accept}}),
        .i_push_tok (res_tok),
        .i_pop      (!i_stall),
        .o_valid    (o_valid),
        .o_full     (q_full),
        .o_head     (head)
    );

    // head token fanned out to the field ports
    assign o_token_kind     = head.kind;
    assign o_name_text      = head.name_text;
    assign o_name_length    = head.name_length;
    assign o_name_truncated = head.name_truncated;
    assign o_int_part       = head.int_part;
    assign o_int_saturated  = head.int_saturated;
    assign o_frac_digits    = head.frac_digits;
    assign o_frac_count     = head.frac_count;
    assign o_error_code     = head.error_code;
    assign o_error_char     = head.error_char;
    assign o_last           = head.last;

endmodule
